/* design/bfgr_pkg.sv */
package bfgr_pkg;

  localparam int FontBytesDef     = 4096;
  localparam int MaxGlyphWidthDef  = 32;
  localparam int MaxGlyphHeightDef = 32;
  localparam int RowLimit          = 32;
  localparam logic [15:0] TablePtrAddr = 16'd15;
  localparam logic [7:0]  CodeLimit    = 8'd127;
  localparam logic [7:0]  CodeSubst    = 8'd63;

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TBL_LO,
    ST_TBL_HI,
    ST_ENT_LO,
    ST_ENT_HI,
    ST_W_LO,
    ST_W_HI,
    ST_H_LO,
    ST_H_HI,
    ST_SIZE,
    ST_ROW_RD,
    ST_ROW_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               cmd;
    logic [11:0]        load_address;
    logic [7:0]         load_data;
    logic [7:0]         char_code;
    logic               start_text;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] row_x;
    logic signed [15:0] row_y;
    logic [31:0]        row_bits;
    logic               row_valid;
    logic [8:0]         glyph_advance;
    logic [15:0]        text_width;
    logic [8:0]         text_height;
    logic               last_row;
  } out_word_t;

endpackage

/* design/bfgr_ram.sv */
module bfgr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/bitmap_font_glyph_rasterizer_core.sv */
// Load words never raise busy.
// A render word holds busy through the table and header reads and sizing, then per glyph
// row through one read of each row byte and an emit state.
// The font memory has a single read port; a new word is taken only while busy is low.
// Results appear one per cycle of emission with strobe_o and cannot be stalled.
// rst_ni is asynchronous, active low; it clears pen, totals and scale to 1, not the font memory.
module bitmap_font_glyph_rasterizer_core #(
  parameter int FontBytes      = bfgr_pkg::FontBytesDef,
  parameter int MaxGlyphWidth  = bfgr_pkg::MaxGlyphWidthDef,
  parameter int MaxGlyphHeight = bfgr_pkg::MaxGlyphHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bfgr_pkg::in_word_t  in_word_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_data_i,
  output logic                strobe_o,
  output bfgr_pkg::out_word_t out_word_o
);
  import bfgr_pkg::*;

  localparam int AW = $clog2(FontBytes);

  // Control state.
  state_e state_q, state_d;
  logic [3:0]  scale_q;
  logic [15:0] pen_x_q, pen_y_q, width_tot_q;
  logic [8:0]  height_max_q;

  // Per-character working registers.
  logic [15:0] addr_q, addr_d;     // running read pointer
  logic [7:0]  lo_q;                // low byte of a 16-bit fetch
  logic [7:0]  code_q;
  logic [15:0] glyph_q;
  logic [6:0]  w_q;                 // clamped width
  logic [6:0]  h_q;                 // clamped height
  logic [5:0]  row_q;
  logic [2:0]  byte_q;
  logic [3:0]  eff_scale_q;
  logic [31:0] bits_q;
  logic [15:0] row_y_q;

  // Memory.
  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          load_acc;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign load_acc    = start && !busy && (in_word_i.cmd == CMD_LOAD);
  assign mem_we      = load_acc && ({5'd0, in_word_i.load_address} < 17'(FontBytes));
  assign mem_raddr   = addr_d[AW-1:0];

  bfgr_ram #(.Width(8), .Depth(FontBytes)) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(AW'(in_word_i.load_address)),
    .wdata_i(in_word_i.load_data),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  logic [15:0] rd16;
  assign rd16 = {mem_rdata, lo_q};

  logic [3:0] stride;
  assign stride = 4'((w_q + 7'd7) >> 3);
  logic [2:0] nbytes; // bytes reported in row_bits (columns below 32)
  assign nbytes = (stride > 4'd4) ? 3'd4 : stride[2:0];
  logic [6:0] rows;
  assign rows = (h_q > 7'(RowLimit)) ? 7'(RowLimit) : h_q;

  logic [10:0] adv_full, hs_full;
  assign adv_full = w_q * eff_scale_q;
  assign hs_full  = h_q * eff_scale_q;
  logic [8:0] adv_sat;
  assign adv_sat = (adv_full > 11'd511) ? 9'd511 : adv_full[8:0];

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (start && in_word_i.cmd == CMD_RENDER) state_d = ST_TBL_LO;
      ST_TBL_LO:   state_d = ST_TBL_HI;
      ST_TBL_HI:   state_d = ST_ENT_LO;
      ST_ENT_LO:   state_d = ST_ENT_HI;
      ST_ENT_HI:   state_d = ST_W_LO;
      ST_W_LO:     state_d = ST_W_HI;
      ST_W_HI:     state_d = ST_H_LO;
      ST_H_LO:     state_d = ST_H_HI;
      ST_H_HI:     state_d = ST_SIZE;
      ST_SIZE:     state_d = (rows == 7'd0 || nbytes == 3'd0) ? ST_EMIT : ST_ROW_RD;
      ST_ROW_RD:   state_d = ST_ROW_WAIT;
      ST_ROW_WAIT: state_d = (byte_q + 3'd1 == nbytes) ? ST_EMIT : ST_ROW_RD;
      ST_EMIT: begin
        if (rows == 7'd0 || 7'(row_q) + 7'd1 >= rows) state_d = ST_IDLE;
        else if (nbytes == 3'd0) state_d = ST_EMIT;
        else state_d = ST_ROW_RD;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Read address: the memory is addressed with the next pointer.
  always_comb begin
    addr_d = addr_q;
    case (state_q)
      ST_IDLE:     addr_d = TablePtrAddr;
      ST_TBL_LO:   addr_d = addr_q + 16'd1;
      ST_TBL_HI:   addr_d = rd16 + {7'd0, code_q, 1'b0};
      ST_ENT_LO:   addr_d = addr_q + 16'd1;
      ST_ENT_HI:   addr_d = rd16;
      ST_W_LO:     addr_d = addr_q + 16'd1;
      ST_W_HI:     addr_d = addr_q + 16'd1;
      ST_H_LO:     addr_d = addr_q + 16'd1;
      ST_H_HI:     addr_d = addr_q + 16'd1;
      ST_SIZE:     addr_d = addr_q;
      ST_ROW_RD:   addr_d = addr_q;
      ST_ROW_WAIT: addr_d = addr_q + 16'd1;
      ST_EMIT:     addr_d = glyph_q + 16'd4 + 16'(row_q + 6'd1) * 16'(stride);
      default:     addr_d = addr_q;
    endcase
  end

  logic [6:0] clamp_w, clamp_h;
  assign clamp_w = (rd16 > 16'(MaxGlyphWidth))  ? 7'(MaxGlyphWidth)  : rd16[6:0];
  assign clamp_h = (rd16 > 16'(MaxGlyphHeight)) ? 7'(MaxGlyphHeight) : rd16[6:0];

  logic [16:0] wsum;
  assign wsum = {1'b0, width_tot_q} + {6'd0, adv_full};
  logic [8:0] hs_sat;
  assign hs_sat = (hs_full > 11'd511) ? 9'd511 : hs_full[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scale_q      <= 4'd1;
      pen_x_q      <= '0;
      pen_y_q      <= '0;
      width_tot_q  <= '0;
      height_max_q <= '0;
      strobe_o     <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_o <= (state_q == ST_EMIT);
      if (cfg_valid_i && cfg_ready_o) scale_q <= cfg_data_i;
      if (state_q == ST_IDLE && start && in_word_i.cmd == CMD_RENDER &&
          in_word_i.start_text) begin
        pen_x_q      <= in_word_i.start_x;
        pen_y_q      <= in_word_i.start_y;
        width_tot_q  <= '0;
        height_max_q <= '0;
      end
      if (state_q == ST_SIZE) begin
        width_tot_q <= wsum[16] ? 16'hFFFF : wsum[15:0];
        if (hs_sat > height_max_q) height_max_q <= hs_sat;
        pen_x_q <= pen_x_q + {5'd0, adv_full};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    lo_q   <= mem_rdata;
    case (state_q)
      ST_IDLE: begin
        code_q      <= (in_word_i.char_code > CodeLimit) ? CodeSubst : in_word_i.char_code;
        eff_scale_q <= (scale_q == 4'd0) ? 4'd1 : ((scale_q > 4'd8) ? 4'd8 : scale_q);
      end
      ST_ENT_HI: glyph_q <= rd16;
      ST_W_HI:   w_q <= clamp_w;
      ST_H_HI:   h_q <= clamp_h;
      ST_SIZE: begin
        row_q   <= '0;
        byte_q  <= '0;
        bits_q  <= '0;
        row_y_q <= pen_y_q;
        out_word_o.row_x <= pen_x_q;
      end
      ST_ROW_WAIT: begin
        for (int k = 0; k < 8; k++) begin
          if ({1'b0, byte_q, 3'(k)} < w_q || w_q > 7'd31) begin
            bits_q[{byte_q[1:0], 3'(k)}] <= mem_rdata[7-k];
          end
        end
        byte_q <= byte_q + 3'd1;
      end
      ST_EMIT: begin
        out_word_o.row_y         <= row_y_q;
        out_word_o.row_bits      <= (rows == 7'd0) ? 32'd0 : bits_q;
        out_word_o.row_valid     <= (rows != 7'd0);
        out_word_o.glyph_advance <= adv_sat;
        out_word_o.text_width    <= width_tot_q;
        out_word_o.text_height   <= height_max_q;
        out_word_o.last_row      <= (state_d == ST_IDLE);
        row_q   <= row_q + 6'd1;
        byte_q  <= '0;
        bits_q  <= '0;
        row_y_q <= row_y_q + {12'd0, eff_scale_q};
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_no_busy_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_word_i.cmd == CMD_LOAD) |=> !busy) else $error("load made busy");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_ready_o) |-> !busy) else $error("cfg while busy");
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |=> strobe_o) else $error("missing strobe");
`endif
endmodule

/* sim/tb_bitmap_font_glyph_rasterizer_core.sv */
`timescale 1ns / 100ps

module tb_bitmap_font_glyph_rasterizer_core;
  import bfgr_pkg::*;

  localparam int FontSize  = 4096;
  localparam int CycleCap  = 2000000;
  // Wait well past the end of the largest glyph before a
  // configuration write or the end of the run.
  localparam int DrainWait = 400;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_word_t  in_word_i;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [3:0] cfg_data_i;
  logic      strobe_o;
  out_word_t out_word_o;

  bitmap_font_glyph_rasterizer_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .strobe_o    (strobe_o),
    .out_word_o  (out_word_o)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow of the block: font image, pen, totals and the scale register.
  logic [7:0]  font_img [FontSize];
  logic [15:0] pen_x_q, pen_y_q, width_sum_q;
  logic [8:0]  height_peak_q;
  logic [3:0]  scale_reg;

  out_word_t row_queue[$];
  int        err_cnt;
  int        rows_seen;
  int        renders_sent;
  int        loads_sent;
  int        idle_pct;
  longint    cycle_cnt;

  function automatic logic [15:0] font_rd16(input int addr);
    return {font_img[(addr + 1) % FontSize], font_img[addr % FontSize]};
  endfunction

  // Compute the rows that one render word causes and queue them.
  function automatic void predict_glyph_rows(input in_word_t w);
    int          code, tbl, gly, gw, gh, stride, sc, nrows, cols, raddr, b;
    logic [15:0] base_x;
    logic [31:0] bits;
    out_word_t   o;
    if (w.start_text) begin
      pen_x_q       = w.start_x;
      pen_y_q       = w.start_y;
      width_sum_q   = '0;
      height_peak_q = '0;
    end
    sc = scale_reg;
    if (sc < 1) sc = 1;
    if (sc > 8) sc = 8;
    code = w.char_code;
    if (code > CodeLimit) code = CodeSubst;
    tbl = font_rd16(TablePtrAddr);
    gly = font_rd16(tbl + code * 2);
    gw = font_rd16(gly);
    gh = font_rd16(gly + 2);
    if (gw > 32) gw = 32;
    if (gh > 32) gh = 32;
    stride = (gw + 7) / 8;
    width_sum_q = (width_sum_q + gw * sc > 65535) ? 16'hffff : 16'(width_sum_q + gw * sc);
    if (gh * sc > height_peak_q) height_peak_q = 9'(gh * sc > 511 ? 511 : gh * sc);
    base_x  = pen_x_q;
    pen_x_q = 16'(pen_x_q + gw * sc);
    o.row_x         = base_x;
    o.glyph_advance = 9'(gw * sc > 511 ? 511 : gw * sc);
    o.text_width    = width_sum_q;
    o.text_height   = height_peak_q;
    nrows = gh;
    if (nrows == 0) begin
      o.row_y     = pen_y_q;
      o.row_bits  = '0;
      o.row_valid = 1'b0;
      o.last_row  = 1'b1;
      row_queue.push_back(o);
    end
    cols = gw;
    for (int r = 0; r < nrows; r++) begin
      bits  = '0;
      raddr = gly + 4 + r * stride;
      for (int k = 0; k < cols; k++) begin
        b = font_img[(raddr + k / 8) % FontSize];
        if (b & (8'h80 >> (k % 8))) bits[k] = 1'b1;
      end
      o.row_y     = 16'(pen_y_q + r * sc);
      o.row_bits  = bits;
      o.row_valid = 1'b1;
      o.last_row  = (r + 1 == nrows);
      row_queue.push_back(o);
    end
  endfunction

  // Result checker: every strobe is compared with the oldest expected row.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && strobe_o) begin
      if (row_queue.size() == 0) begin
        $error("unexpected result word %h", out_word_o);
        err_cnt++;
      end else begin
        out_word_t e;
        e = row_queue.pop_front();
        rows_seen++;
        if (out_word_o.row_x !== e.row_x) begin
          $error("row_x exp %0d got %0d", e.row_x, out_word_o.row_x); err_cnt++;
        end
        if (out_word_o.row_y !== e.row_y) begin
          $error("row_y exp %0d got %0d", e.row_y, out_word_o.row_y); err_cnt++;
        end
        if (out_word_o.row_bits !== e.row_bits) begin
          $error("row_bits exp %h got %h", e.row_bits, out_word_o.row_bits); err_cnt++;
        end
        if (out_word_o.row_valid !== e.row_valid) begin
          $error("row_valid exp %0d got %0d", e.row_valid, out_word_o.row_valid); err_cnt++;
        end
        if (out_word_o.glyph_advance !== e.glyph_advance) begin
          $error("glyph_advance exp %0d got %0d", e.glyph_advance,
                 out_word_o.glyph_advance); err_cnt++;
        end
        if (out_word_o.text_width !== e.text_width) begin
          $error("text_width exp %0d got %0d", e.text_width, out_word_o.text_width);
          err_cnt++;
        end
        if (out_word_o.text_height !== e.text_height) begin
          $error("text_height exp %0d got %0d", e.text_height, out_word_o.text_height);
          err_cnt++;
        end
        if (out_word_o.last_row !== e.last_row) begin
          $error("last_row exp %0d got %0d", e.last_row, out_word_o.last_row); err_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    if (cycle_cnt > CycleCap) begin
      $display("bitmap_font_glyph_rasterizer_core verification failed");
      $finish;
    end
  end

  // Send one word: optional idle gap, then hold start until it is taken.
  // start stays high on return; the next word, an idle cycle or a drain
  // replaces it at the same falling edge.
  task automatic send_word(input in_word_t w);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start     <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (w.cmd == CMD_LOAD) begin
      if (w.load_address < FontSize) begin
        font_img[w.load_address] = w.load_data;
      end
      loads_sent++;
    end else begin
      predict_glyph_rows(w);
      renders_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic load_byte(input int addr, input int val);
    in_word_t w;
    w = '0;
    w.cmd          = CMD_LOAD;
    w.load_address = 12'(addr);
    w.load_data    = 8'(val);
    w.char_code    = 8'($urandom);
    w.start_x      = 16'($urandom);
    send_word(w);
  endtask

  task automatic load_half(input int addr, input int val);
    load_byte(addr, val & 8'hff);
    load_byte(addr + 1, (val >> 8) & 8'hff);
  endtask

  task automatic render_char(input int code, input bit new_text);
    in_word_t w;
    w = '0;
    w.cmd          = CMD_RENDER;
    w.char_code    = 8'(code);
    w.start_text   = new_text;
    w.start_x      = 16'($urandom);
    w.start_y      = 16'($urandom);
    w.load_address = 12'($urandom);
    w.load_data    = 8'($urandom);
    send_word(w);
  endtask

  // Let the block finish and drain before a register write or the end.
  task automatic wait_drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (row_queue.size() != 0 && n < 100000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_scale(input int val);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 4'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    scale_reg = 4'(val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Glyphs live at fixed slots past the table: slot g at 320 + 160*g,
  // room for 32 rows x 4 bytes.
  function automatic int slot_addr(input int g);
    return 320 + 160 * g;
  endfunction

  // Write a glyph header and fully populated rows; every byte of the glyph
  // region up to its stride is written, so no unwritten byte is ever read.
  task automatic write_glyph(input int g, input int gw, input int gh, input bit rnd);
    int a, cw, ch, st;
    a  = slot_addr(g);
    cw = gw > 32 ? 32 : gw;
    ch = gh > 32 ? 32 : gh;
    st = (cw + 7) / 8;
    load_half(a, gw);
    load_half(a + 2, gh);
    for (int i = 0; i < ch * st; i++)
      load_byte(a + 4 + i, rnd ? $urandom_range(255, 0) : ((i & 1) ? 8'hff : 8'h00));
  endtask

  // Table at 64: every one of the 128 entries points at one of 20 slots.
  task automatic test_font_setup();
    load_half(15, 64);
    load_byte(14, 8'hff);
    for (int c = 0; c < 128; c++) load_half(64 + 2 * c, slot_addr(c % 20));
    write_glyph(0, 0, 0, 1'b0);
    write_glyph(1, 8, 0, 1'b0);
    write_glyph(2, 0, 5, 1'b0);
    write_glyph(3, 32, 32, 1'b1);
    write_glyph(4, 16'hffff, 16'hffff, 1'b1);
    write_glyph(5, 1, 1, 1'b1);
    write_glyph(6, 33, 2, 1'b1);
    write_glyph(7, 7, 40, 1'b1);
    for (int g = 8; g < 20; g++)
      write_glyph(g, $urandom_range(12, 1), $urandom_range(6, 1), 1'b1);
    // Larger addresses would wrap in the 12-bit field; the top byte, 4095, still fits.
    load_byte(4095, 8'h5a);
  endtask

  task automatic test_directed();
    render_char(0, 1'b1);     // zero width and height
    render_char(1, 1'b0);     // zero height, nonzero width
    render_char(2, 1'b0);     // zero width, rows of nothing
    render_char(3, 1'b1);     // largest glyph
    render_char(4, 1'b0);     // clamped sizes
    render_char(5, 1'b0);
    render_char(6, 1'b0);     // wide glyph
    render_char(7, 1'b0);     // tall glyph
    render_char(255, 1'b0);   // codes above 127 become '?'
    render_char(128, 1'b1);
    render_char(127, 1'b0);
    render_char(63, 1'b0);
  endtask

  // Mostly renders of small glyphs with random content, some loads as noise.
  task automatic test_random(input int n_items);
    int c;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9, 0) < 2) begin
        c = slot_addr($urandom_range(19, 8)) + 4 + $urandom_range(3, 0);
        load_byte(c, $urandom_range(255, 0));
      end else begin
        c = $urandom_range(9, 0) == 0 ? $urandom_range(255, 0)
                                      : 8 + 20 * $urandom_range(5, 0) + $urandom_range(11, 0);
        if (c < 128 && (c % 20) < 8 && $urandom_range(3, 0) != 0) c = 8 + (c % 12);
        render_char(c, $urandom_range(7, 0) == 0);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    in_word_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    renders_sent  = 0;
    loads_sent    = 0;
    idle_pct      = 0;
    scale_reg     = 4'd1;
    pen_x_q       = '0;
    pen_y_q       = '0;
    width_sum_q   = '0;
    height_peak_q = '0;
    for (int i = 0; i < FontSize; i++) begin
      font_img[i] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_font_setup();
    test_directed();
    write_scale(8);
    test_directed();
    write_scale(0);
    render_char(3, 1'b1);
    write_scale(15);
    render_char(4, 1'b1);
    render_char(3, 1'b0);

    // Random phases with various scales and sender idling.
    write_scale(1);
    idle_pct = 0;
    test_random(50);
    write_scale(3);
    idle_pct = 59;
    test_random(50);
    write_scale(8);
    idle_pct = 29;
    test_random(50);
    write_scale(2);
    idle_pct = 0;
    test_random(50);

    wait_drain();
    $display("Covered %0d load and %0d render words, %0d rows checked,",
             loads_sent, renders_sent, rows_seen);
    $display("over scales 0, 1, 2, 3, 8 and 15 and several idle mixes.");
    if (err_cnt == 0 && row_queue.size() == 0) begin
      $display("bitmap_font_glyph_rasterizer_core verification clean");
    end else begin
      $display("bitmap_font_glyph_rasterizer_core verification failed");
    end
    $finish;
  end

endmodule
